[hw/rtl/gpvd_pkg.sv]
// shared types and constants of the grid peak and valley detector
package gpvd_pkg;

	// fixed widths of the configuration register and the result coordinates
	localparam int GRID_SIDE_BITS = 9;
	localparam int COORD_BITS     = 8;

	// which cell of the window a result classifies, in raster order
	typedef enum logic [1:0] {
		CELL_UL = 2'd0,
		CELL_UR = 2'd1,
		CELL_LL = 2'd2,
		CELL_LR = 2'd3
	} cell_sel_t;

	// per-item control from the line stage to the emitter
	typedef struct packed {
		logic [3:0] pending;
		logic       row_ge1;
		logic       row_ge2;
		logic       col_ge1;
		logic       col_ge2;
	} item_ctrl_t;

endpackage

[hw/rtl/gpvd_ram.sv]
// generic single-write, single-read ram with registered read data
module gpvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/gpvd_window.sv]
// 3x3 window registers, shifted left by one column per beat
module gpvd_window #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  logic [SAMPLE_BITS-1:0]      up2,
	input  logic [SAMPLE_BITS-1:0]      up1,
	input  logic [SAMPLE_BITS-1:0]      x,
	output logic [8:0][SAMPLE_BITS-1:0] win
);

	// element (i, j) sits at index 3*i + j: rows r-2..r, columns c-2..c
	logic [8:0][SAMPLE_BITS-1:0] win_q;

	// shift in the new right column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[3*i]     <= win_q[3*i + 1];
				win_q[3*i + 1] <= win_q[3*i + 2];
			end
			win_q[2] <= up2;
			win_q[5] <= up1;
			win_q[8] <= x;
		end
	end

	assign win = win_q;

endmodule

[hw/rtl/gpvd_emit.sv]
// result emitter: classifies the pending cells of one item, one result per beat
module gpvd_emit #(
	parameter int MAX_SIDE    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          load,
	input  gpvd_pkg::item_ctrl_t                          ctrl,
	input  logic [(MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1)-1:0] row_in,
	input  logic [(MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1)-1:0] col_in,
	input  logic [8:0][SAMPLE_BITS-1:0]                   win,
	output logic                                          free,
	output logic                                          result_valid,
	input  logic                                          result_stall,
	output logic [gpvd_pkg::COORD_BITS-1:0]               column,
	output logic [gpvd_pkg::COORD_BITS-1:0]               row,
	output logic                                          is_peak,
	output logic                                          is_valley,
	output logic                                          last_of_run,
	output logic                                          grid_done
);

	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int KW = gpvd_pkg::COORD_BITS;

	// item held for emission
	logic [3:0]    pend_s2;
	logic [CW-1:0] row_s2;
	logic [CW-1:0] col_s2;
	logic [2:0]    row_ok_s2;
	logic [2:0]    col_ok_s2;

	// output register
	logic          out_valid_q;
	logic [KW-1:0] column_q;
	logic [KW-1:0] row_q;
	logic          peak_q;
	logic          valley_q;
	logic          last_q;
	logic          done_q;

	gpvd_pkg::cell_sel_t sel;
	logic [1:0]          sel_bits;
	logic [3:0]          sel_onehot;
	logic [3:0]          pend_after;
	logic                out_free;
	logic                emit;
	logic [1:0]          ci;
	logic [1:0]          cj;
	logic [3:0]          center_idx;
	logic [SAMPLE_BITS-1:0] center;
	logic                peak;
	logic                valley;
	logic [CW-1:0]       grid_r;
	logic [CW-1:0]       grid_c;
	logic [KW-1:0]       grid_r8;
	logic [KW-1:0]       grid_c8;

	// lowest pending cell goes first
	always_comb begin
		if (pend_s2[0]) begin
			sel = gpvd_pkg::CELL_UL;
		end else if (pend_s2[1]) begin
			sel = gpvd_pkg::CELL_UR;
		end else if (pend_s2[2]) begin
			sel = gpvd_pkg::CELL_LL;
		end else begin
			sel = gpvd_pkg::CELL_LR;
		end
	end

	assign sel_bits   = sel;
	assign sel_onehot = 4'b0001 << sel_bits;

	// emission handshake
	assign out_free   = !out_valid_q || !result_stall;
	assign emit       = (pend_s2 != 4'b0000) && out_free;
	assign pend_after = emit ? (pend_s2 & ~sel_onehot) : pend_s2;
	assign free       = (pend_after == 4'b0000);

	// center position in the window
	always_comb begin
		case (sel)
			gpvd_pkg::CELL_UL: center_idx = 4'd4;
			gpvd_pkg::CELL_UR: center_idx = 4'd5;
			gpvd_pkg::CELL_LL: center_idx = 4'd7;
			gpvd_pkg::CELL_LR: center_idx = 4'd8;
			default:           center_idx = 4'd4;
		endcase
	end

	assign ci     = sel_bits[1] ? 2'd2 : 2'd1;
	assign cj     = sel_bits[0] ? 2'd2 : 2'd1;
	assign center = win[center_idx];

	// compare the center against every neighbour that lies in the grid
	always_comb begin
		logic near;
		logic in_grid;
		peak   = 1'b1;
		valley = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				near = (2'(i) + 2'd1 >= ci) && (2'(j) + 2'd1 >= cj)
					&& !((2'(i) == ci) && (2'(j) == cj));
				in_grid = row_ok_s2[i] && col_ok_s2[j];
				if (near && in_grid) begin
					if (!($signed(center) > $signed(win[3*i + j]))) begin
						peak = 1'b0;
					end
					if (!($signed(center) < $signed(win[3*i + j]))) begin
						valley = 1'b0;
					end
				end
			end
		end
	end

	// grid coordinates of the selected cell
	assign grid_r = sel_bits[1] ? row_s2 : row_s2 - CW'(1);
	assign grid_c = sel_bits[0] ? col_s2 : col_s2 - CW'(1);

	generate
		if (CW >= KW) begin : g_coord_trunc
			assign grid_r8 = grid_r[KW-1:0];
			assign grid_c8 = grid_c[KW-1:0];
		end else begin : g_coord_ext
			assign grid_r8 = {{(KW-CW){1'b0}}, grid_r};
			assign grid_c8 = {{(KW-CW){1'b0}}, grid_c};
		end
	endgenerate

	// pending mask, reloaded when the line stage hands over an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 4'b0000;
		end else if (load) begin
			pend_s2 <= ctrl.pending;
		end else begin
			pend_s2 <= pend_after;
		end
	end

	// item position and neighbour row and column masks
	always_ff @(posedge clk) begin
		if (load) begin
			row_s2    <= row_in;
			col_s2    <= col_in;
			row_ok_s2 <= {1'b1, ctrl.row_ge1, ctrl.row_ge2};
			col_ok_s2 <= {1'b1, ctrl.col_ge1, ctrl.col_ge2};
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			column_q <= grid_c8;
			row_q    <= grid_r8;
			peak_q   <= peak;
			valley_q <= valley;
			last_q   <= (pend_after == 4'b0000);
			done_q   <= (sel == gpvd_pkg::CELL_LR);
		end
	end

	assign result_valid = out_valid_q;
	assign column       = column_q;
	assign row          = row_q;
	assign is_peak      = peak_q;
	assign is_valley    = valley_q;
	assign last_of_run  = last_q;
	assign grid_done    = done_q;

endmodule

[hw/rtl/grid_peak_valley_detector.sv]
// top level of the 3x3 grid peak and valley detector
//
// Samples of a square grid enter in raster order on sample / sample_valid, and
// sample_stall holds them off. Each result (column, row, is_peak, is_valley,
// last_of_run, grid_done) leaves on result_valid and waits while result_stall
// is high. A cell is reported once its in-grid neighbours have arrived, so one
// sample causes zero to four results; last_of_run marks the last result of a
// sample and grid_done the bottom-right cell of the grid.
// grid_side_we with grid_side sets the side (0 acts as 1, values above
// MAX_SIDE act as MAX_SIDE) and restarts the grid; write only when idle.
// A sample goes via the line stage and pending mask to the result register.
// Throughput: one sample per cycle while result_stall is low and each sample
// causes at most one result; a sample causing more holds the input until its last
// enters the single result register, which emits one beat per cycle when unstalled.
// The row stores are one ram of MAX_SIDE words read at the next column and
// written back when the line stage advances; a same-column read is forwarded.
// Reset: side 1, position at row 0 column 0, window zero, no results pending;
// the ram is not cleared, its stale words only reach ignored window positions.
module grid_peak_valley_detector #(
	parameter int MAX_SIDE    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   grid_side_we,
	input  logic [gpvd_pkg::GRID_SIDE_BITS-1:0]    grid_side,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic [SAMPLE_BITS-1:0]                 sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic [gpvd_pkg::COORD_BITS-1:0]        column,
	output logic [gpvd_pkg::COORD_BITS-1:0]        row,
	output logic                                   is_peak,
	output logic                                   is_valley,
	output logic                                   last_of_run,
	output logic                                   grid_done
);

	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int WW = 2 * SAMPLE_BITS;

	// configuration and position
	logic [CW-1:0] side_last_q;
	logic [CW-1:0] side_last_d;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;

	// line stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] x_s1;
	logic [CW-1:0]          row_s1;
	logic [CW-1:0]          col_s1;
	logic                   fwd_s1;
	logic [WW-1:0]          fwd_data_s1;

	logic                   accept;
	logic                   adv1;
	logic                   emit_free;
	logic [WW-1:0]          ram_rdata;
	logic [WW-1:0]          store_word;
	logic [SAMPLE_BITS-1:0] up2;
	logic [SAMPLE_BITS-1:0] up1;
	logic [WW-1:0]          wb_word;
	logic [8:0][SAMPLE_BITS-1:0] win;
	gpvd_pkg::item_ctrl_t   ctrl;
	logic                   r_last;
	logic                   c_last;
	logic                   r_ge1;
	logic                   c_ge1;

	// handshake
	assign adv1         = valid_s1 && emit_free;
	assign sample_stall = valid_s1 && !adv1;
	assign accept       = sample_valid && !sample_stall;

	// clamp the written side, stored as side minus one
	always_comb begin
		if (grid_side == '0) begin
			side_last_d = '0;
		end else if (int'(grid_side) > MAX_SIDE) begin
			side_last_d = CW'(MAX_SIDE - 1);
		end else begin
			side_last_d = CW'(grid_side - 9'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_last_q <= '0;
		end else if (grid_side_we) begin
			side_last_q <= side_last_d;
		end
	end

	// raster position of the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (grid_side_we) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == side_last_q) begin
				col_q <= '0;
				row_q <= (row_q == side_last_q) ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	// line stage payload and forwarding of a same-column write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= sample;
			row_s1      <= row_q;
			col_s1      <= col_q;
			fwd_s1      <= adv1 && (col_s1 == col_q);
			fwd_data_s1 <= wb_word;
		end
	end

	// row stores: upper half is two rows up, lower half one row up
	gpvd_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_SIDE)
	) u_rows (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (wb_word),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign store_word = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign up2        = store_word[WW-1:SAMPLE_BITS];
	assign up1        = store_word[SAMPLE_BITS-1:0];
	assign wb_word    = {up1, x_s1};

	gpvd_window #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv1),
		.up2    (up2),
		.up1    (up1),
		.x      (x_s1),
		.win    (win)
	);

	// which cells become complete with this sample
	assign r_last = (row_s1 == side_last_q);
	assign c_last = (col_s1 == side_last_q);
	assign r_ge1  = (row_s1 != '0);
	assign c_ge1  = (col_s1 != '0);

	always_comb begin
		ctrl.pending[0] = r_ge1 && c_ge1;
		ctrl.pending[1] = r_ge1 && c_last;
		ctrl.pending[2] = r_last && c_ge1;
		ctrl.pending[3] = r_last && c_last;
		ctrl.row_ge1    = r_ge1;
		ctrl.row_ge2    = r_ge1 && (row_s1 != CW'(1));
		ctrl.col_ge1    = c_ge1;
		ctrl.col_ge2    = c_ge1 && (col_s1 != CW'(1));
	end

	gpvd_emit #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv1),
		.ctrl         (ctrl),
		.row_in       (row_s1),
		.col_in       (col_s1),
		.win          (win),
		.free         (emit_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.column       (column),
		.row          (row),
		.is_peak      (is_peak),
		.is_valley    (is_valley),
		.last_of_run  (last_of_run),
		.grid_done    (grid_done)
	);

endmodule

[hw/rtl/gpvd_checker.sv]
// port-level checks of the grid peak and valley detector, bound to the top level
module gpvd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [gpvd_pkg::COORD_BITS-1:0] column,
	input logic [gpvd_pkg::COORD_BITS-1:0] row,
	input logic                            is_peak,
	input logic                            is_valley,
	input logic                            last_of_run,
	input logic                            grid_done
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(column) && $stable(row)
			&& $stable(is_peak) && $stable(is_valley) && $stable(last_of_run)
			&& $stable(grid_done))
		else $error("stalled result changed");

	// the bottom-right cell is always the last result of its sample
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && grid_done |-> last_of_run)
		else $error("grid end without end of run");

	// the bottom-right cell lies on the diagonal
	a_done_diag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && grid_done |-> column == row)
		else $error("grid end off the diagonal");

	// only a cell with no neighbours can be both peak and valley
	a_both_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_peak && is_valley |-> grid_done && column == '0 && row == '0)
		else $error("peak and valley on a cell with neighbours");

endmodule

bind grid_peak_valley_detector gpvd_checker u_gpvd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.column       (column),
	.row          (row),
	.is_peak      (is_peak),
	.is_valley    (is_valley),
	.last_of_run  (last_of_run),
	.grid_done    (grid_done)
);

[dv/testbench.sv]
// self-checking testbench of the grid peak and valley detector
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SIDE    = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int END_DRAIN   = 5000;

	// one classified cell, as it leaves the block
	typedef struct packed {
		logic [7:0] column;
		logic [7:0] row;
		logic       is_peak;
		logic       is_valley;
		logic       last_of_run;
		logic       grid_done;
	} cell_result_t;

	// one row of the directed plan: a side write or a sample beat
	typedef enum bit {
		KIND_SAMPLE = 1'b0,
		KIND_SIDE   = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [8:0]       side_val;
		logic [15:0]      value;
		bit               typed;
		cell_result_t     want_cell;
	} plan_row_t;

	// a lone cell has no neighbours, so it is both a peak and a valley
	localparam cell_result_t LONE_CELL = {8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1};
	localparam cell_result_t NO_CELL   = '0;
	localparam int PLAN_ROWS   = 30;
	localparam int NUM_PHASES  = 11;

	logic clk;
	logic arst_n = 1'b0;
	logic grid_side_we = 1'b0;
	logic [gpvd_pkg::GRID_SIDE_BITS-1:0] grid_side = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [gpvd_pkg::COORD_BITS-1:0] column;
	logic [gpvd_pkg::COORD_BITS-1:0] row;
	logic is_peak;
	logic is_valley;
	logic last_of_run;
	logic grid_done;

	grid_peak_valley_detector #(
		.MAX_SIDE   (MAX_SIDE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_side_we(grid_side_we),
		.grid_side   (grid_side),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.column      (column),
		.row         (row),
		.is_peak     (is_peak),
		.is_valley   (is_valley),
		.last_of_run (last_of_run),
		.grid_done   (grid_done)
	);

	// predictor state: line stores, 3x3 window, side and raster position
	logic signed [15:0] older_line [0:MAX_SIDE-1];
	logic signed [15:0] upper_line [0:MAX_SIDE-1];
	logic signed [15:0] win [0:2][0:2];
	logic [8:0] side_setting;
	int unsigned next_row;
	int unsigned next_col;
	cell_result_t step_cells [0:3];
	int step_count;

	cell_result_t pending_cells [$];
	int mismatch_count = 0;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;

	plan_row_t plan [0:PLAN_ROWS-1];
	int unsigned phase_side [0:NUM_PHASES-1];
	int unsigned phase_len [0:NUM_PHASES-1];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// classify the window cell (wr, wc) sitting at grid cell (gr, gc)
	function automatic cell_result_t classify_cell(input int wr, input int wc, input int gr,
			input int gc, input int s);
		cell_result_t res;
		logic signed [15:0] centre;
		logic signed [15:0] nb;
		int nr;
		int nc;
		int pr;
		int pc;
		centre = win[wr][wc];
		res = '0;
		res.column = gc[7:0];
		res.row = gr[7:0];
		res.is_peak = 1'b1;
		res.is_valley = 1'b1;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				nr = gr + dr;
				nc = gc + dc;
				pr = wr + dr;
				pc = wc + dc;
				// neighbours off the grid do not count
				if (!(dr == 0 && dc == 0) && nr >= 0 && nc >= 0 && nr < s && nc < s &&
						pr >= 0 && pr <= 2 && pc >= 0 && pc <= 2) begin
					nb = win[pr][pc];
					if (!(centre > nb))
						res.is_peak = 1'b0;
					if (!(centre < nb))
						res.is_valley = 1'b0;
				end
			end
		end
		res.grid_done = (gr == s - 1 && gc == s - 1);
		return res;
	endfunction

	// advance the predictor by one accepted sample and queue its cells
	task automatic predict_sample(input logic [15:0] raw, input bit typed,
			input cell_result_t typed_cell);
		int s;
		int r;
		int c;
		logic signed [15:0] x;
		logic signed [15:0] up2;
		logic signed [15:0] up1;
		// side of zero acts as one, oversize acts as the maximum
		s = side_setting;
		if (s == 0)
			s = 1;
		if (s > MAX_SIDE)
			s = MAX_SIDE;
		r = next_row;
		c = next_col;
		if (r >= s || c >= s) begin
			r = 0;
			c = 0;
		end
		x = raw;
		up2 = older_line[c];
		up1 = upper_line[c];
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = x;
		older_line[c] = up1;
		upper_line[c] = x;
		// cells completed by this sample, in raster order
		step_count = 0;
		if (r >= 1 && c >= 1) begin
			step_cells[step_count] = classify_cell(1, 1, r - 1, c - 1, s);
			step_count++;
		end
		if (r >= 1 && c == s - 1) begin
			step_cells[step_count] = classify_cell(1, 2, r - 1, c, s);
			step_count++;
		end
		if (r == s - 1 && c >= 1) begin
			step_cells[step_count] = classify_cell(2, 1, r, c - 1, s);
			step_count++;
		end
		if (r == s - 1 && c == s - 1) begin
			step_cells[step_count] = classify_cell(2, 2, r, c, s);
			step_count++;
		end
		if (step_count > 0)
			step_cells[step_count-1].last_of_run = 1'b1;
		// raster position, wrapping into a new grid after the last cell
		c++;
		if (c >= s) begin
			c = 0;
			r++;
			if (r >= s)
				r = 0;
		end
		next_row = r;
		next_col = c;
		if (typed)
			pending_cells.push_back(typed_cell);
		else begin
			for (int i = 0; i < step_count; i++)
				pending_cells.push_back(step_cells[i]);
		end
	endtask

	// offer one sample beat after a random gap, then predict on acceptance
	task automatic send_sample(input logic [15:0] value, input bit typed,
			input cell_result_t typed_cell);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (sample_stall);
		predict_sample(value, typed, typed_cell);
	endtask

	// write the side once the block has drained; this also restarts the grid
	task automatic write_side(input logic [8:0] value);
		sample_valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		// a trailing sample with no cells may still be in flight
		repeat (8) @(posedge clk);
		grid_side_we <= 1'b1;
		grid_side <= value;
		@(posedge clk);
		grid_side_we <= 1'b0;
		side_setting = value;
		next_row = 0;
		next_col = 0;
	endtask

	// random sample mix: full range, ties near zero, extremes, low plateau
	function automatic logic [15:0] pick_sample();
		logic [15:0] v;
		case ($urandom_range(0, 3))
			0: v = 16'($urandom);
			1: v = 16'($urandom_range(0, 4)) - 16'd2;
			2: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: v = 16'($urandom_range(0, 8));
		endcase
		return v;
	endfunction

	// result side: random stall per beat, plus one long hold on request
	initial begin
		int wait_cycles;
		wait (arst_n === 1'b1);
		forever begin
			wait_cycles = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_request) begin
				wait_cycles = 120;
				hold_request = 1'b0;
			end
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
		end
	end

	// compare every accepted result beat with the oldest expected cell
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_cells.size() == 0)
				report_mismatch($sformatf("unexpected cell col %0d row %0d", column, row));
			else begin
				want = pending_cells.pop_front();
				if (column !== want.column)
					report_mismatch($sformatf("column got %0d want %0d", column, want.column));
				if (row !== want.row)
					report_mismatch($sformatf("row got %0d want %0d", row, want.row));
				if (is_peak !== want.is_peak)
					report_mismatch($sformatf("is_peak at %0d,%0d got %b want %b",
						want.column, want.row, is_peak, want.is_peak));
				if (is_valley !== want.is_valley)
					report_mismatch($sformatf("is_valley at %0d,%0d got %b want %b",
						want.column, want.row, is_valley, want.is_valley));
				if (last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run at %0d,%0d got %b want %b",
						want.column, want.row, last_of_run, want.last_of_run));
				if (grid_done !== want.grid_done)
					report_mismatch($sformatf("grid_done at %0d,%0d got %b want %b",
						want.column, want.row, grid_done, want.grid_done));
			end
		end
	end

	// main sequence
	initial begin
		// predictor reset state
		side_setting = 9'd1;
		next_row = 0;
		next_col = 0;
		for (int i = 0; i < MAX_SIDE; i++) begin
			older_line[i] = '0;
			upper_line[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;

		// directed plan: lone cells, side of zero, ties, extremes, peak, valley, wrap
		plan[0]  = {KIND_SIDE,   9'd1, 16'h0000, 1'b0, NO_CELL};
		plan[1]  = {KIND_SAMPLE, 9'd0, 16'h7FFF, 1'b1, LONE_CELL};
		plan[2]  = {KIND_SAMPLE, 9'd0, 16'h8000, 1'b1, LONE_CELL};
		plan[3]  = {KIND_SIDE,   9'd0, 16'h0000, 1'b0, NO_CELL};
		plan[4]  = {KIND_SAMPLE, 9'd0, 16'h0000, 1'b1, LONE_CELL};
		plan[5]  = {KIND_SAMPLE, 9'd0, 16'hFFFF, 1'b1, LONE_CELL};
		plan[6]  = {KIND_SIDE,   9'd2, 16'h0000, 1'b0, NO_CELL};
		plan[7]  = {KIND_SAMPLE, 9'd0, 16'h8000, 1'b0, NO_CELL};
		plan[8]  = {KIND_SAMPLE, 9'd0, 16'h7FFF, 1'b0, NO_CELL};
		plan[9]  = {KIND_SAMPLE, 9'd0, 16'h7FFF, 1'b0, NO_CELL};
		plan[10] = {KIND_SAMPLE, 9'd0, 16'h8000, 1'b0, NO_CELL};
		plan[11] = {KIND_SIDE,   9'd3, 16'h0000, 1'b0, NO_CELL};
		plan[12] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[13] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[14] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[15] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[16] = {KIND_SAMPLE, 9'd0, 16'h0005, 1'b0, NO_CELL};
		plan[17] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[18] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[19] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[20] = {KIND_SAMPLE, 9'd0, 16'h0001, 1'b0, NO_CELL};
		plan[21] = {KIND_SAMPLE, 9'd0, 16'h0003, 1'b0, NO_CELL};
		plan[22] = {KIND_SAMPLE, 9'd0, 16'h0002, 1'b0, NO_CELL};
		plan[23] = {KIND_SAMPLE, 9'd0, 16'h0003, 1'b0, NO_CELL};
		plan[24] = {KIND_SAMPLE, 9'd0, 16'h0002, 1'b0, NO_CELL};
		plan[25] = {KIND_SAMPLE, 9'd0, 16'h8000, 1'b0, NO_CELL};
		plan[26] = {KIND_SAMPLE, 9'd0, 16'h0002, 1'b0, NO_CELL};
		plan[27] = {KIND_SAMPLE, 9'd0, 16'h0003, 1'b0, NO_CELL};
		plan[28] = {KIND_SAMPLE, 9'd0, 16'h0002, 1'b0, NO_CELL};
		plan[29] = {KIND_SAMPLE, 9'd0, 16'h7FFF, 1'b0, NO_CELL};

		// random phases; several end mid-grid so the next write restarts it
		phase_side = '{4, 5, 3, 1, 7, 2, 0, 9, 256, 6, 511};
		phase_len  = '{32, 32, 27, 8, 49, 20, 4, 81, 12, 9, 10};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed plan
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == KIND_SIDE)
				write_side(plan[i].side_val);
			else
				send_sample(plan[i].value, plan[i].typed, plan[i].want_cell);
		end

		// random part
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_side(phase_side[p][8:0]);
			// long receiver hold while samples keep coming, and one stretch at full rate
			hold_request = (p == 4);
			no_idle = (p == 7);
			for (int k = 0; k < phase_len[p]; k++)
				send_sample(pick_sample(), 1'b0, NO_CELL);
		end
		no_idle = 1'b0;
		sample_valid <= 1'b0;

		// drain, then watch for stray beats
		for (int t = 0; t < END_DRAIN && pending_cells.size() != 0; t++)
			@(posedge clk);
		if (pending_cells.size() != 0)
			report_mismatch($sformatf("%0d expected cells never arrived", pending_cells.size()));
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/gpvd_pkg.sv
hw/rtl/gpvd_ram.sv
hw/rtl/gpvd_window.sv
hw/rtl/gpvd_emit.sv
hw/rtl/grid_peak_valley_detector.sv
hw/rtl/gpvd_checker.sv
dv/testbench.sv
